/* hdl/itp_pkg.sv */
// Shared types, codes and helpers of the infix-to-postfix converter.
// No dependencies; every module of the block imports this package.
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Command queue between the front and the back (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input token kinds
  localparam logic [2:0] TK_NUM    = 3'd0;
  localparam logic [2:0] TK_OP     = 3'd1;
  localparam logic [2:0] TK_LPAREN = 3'd2;
  localparam logic [2:0] TK_RPAREN = 3'd3;

  // Symbol codes
  localparam logic [3:0] SYM_LAST_VALID = 4'd11;
  localparam logic [3:0] SYM_LPAREN     = 4'd12;

  // Result kinds
  localparam logic [1:0] KIND_NUM  = 2'd0;
  localparam logic [1:0] KIND_OP   = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAREN    = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic        command;
    logic [2:0]  token_kind;
    logic [3:0]  symbol_code;
    logic [31:0] number_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  out_symbol;
    logic [31:0] out_number;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NUM,
    OP_PUSH,
    OP_OPER,
    OP_RPAREN,
    OP_INVALID,
    OP_END
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  code;
    logic [2:0]  prec;
    logic [31:0] number;
  } cmd_t;

  function automatic logic [2:0] prec_of(input logic [3:0] code);
    logic [2:0] p;
    if (code <= 4'd1) p = 3'd1;
    else if (code <= 4'd4) p = 3'd2;
    else if (code == 4'd5 || code == 4'd10) p = 3'd3;
    else if (code <= 4'd11) p = 3'd4;
    else p = 3'd0;
    return p;
  endfunction

  function automatic logic is_func(input logic [3:0] code);
    return (code >= 4'd6) && (code <= 4'd11);
  endfunction

endpackage

/* hdl/itp_front.sv */
// Front end: accepts input words, classifies each token into a command
// and queues it for the back end. Depends on itp_pkg.
module itp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  itp_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_pop,
  output itp_pkg::cmd_t    q_data
);
  import itp_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  cmd_t              cls;
  logic              push;

  // Classify the incoming token
  always_comb begin
    cls        = '0;
    cls.op     = OP_INVALID;
    cls.code   = in_data.symbol_code;
    cls.prec   = prec_of(in_data.symbol_code);
    cls.number = in_data.number_bits;
    if (in_data.command) begin
      cls.op = OP_END;
    end else begin
      case (in_data.token_kind)
        TK_NUM:    cls.op = OP_NUM;
        TK_OP: begin
          if (in_data.symbol_code > SYM_LAST_VALID) cls.op = OP_INVALID;
          else if (is_func(in_data.symbol_code)) cls.op = OP_PUSH;
          else cls.op = OP_OPER;
        end
        TK_LPAREN: begin
          cls.op   = OP_PUSH;
          cls.code = SYM_LPAREN;
        end
        TK_RPAREN: cls.op = OP_RPAREN;
        default:   cls.op = OP_INVALID;
      endcase
    end
  end

  assign in_ready = (qcnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (qcnt_r != '0);
  assign q_data   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    qcnt_nxt   = qcnt_r;
    if (push) wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    if (q_pop) rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    if (push && !q_pop) qcnt_nxt = qcnt_r + QCNT_W'(1);
    else if (!push && q_pop) qcnt_nxt = qcnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      qcnt_r   <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* hdl/itp_back.sv */
// Back end: runs queued commands against the operator stack and drives
// the result register. Depends on itp_pkg.
module itp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  itp_pkg::cmd_t      q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output itp_pkg::out_item_t out_data
);
  import itp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  out_item_t        pend_r, pend_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [3:0]       stk_r [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_m1;
  logic [3:0]       top_code;
  logic             empty, full, top_lp, top_fn;
  logic [2:0]       top_prec;
  logic             out_free, can_emit;
  logic             emit, flush, push;
  logic [3:0]       push_code;
  out_item_t        res;
  logic             end_done;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign top_code = stk_r[cnt_m1[IDX_W-1:0]];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign top_lp   = (top_code == SYM_LPAREN);
  assign top_fn   = is_func(top_code);
  assign top_prec = prec_of(top_code);
  assign out_free = !out_valid_r || out_ready;
  // a new result displaces the held one, which needs room downstream
  assign can_emit = !pend_valid_r || out_free;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    q_pop          = 1'b0;
    emit           = 1'b0;
    flush          = 1'b0;
    push           = 1'b0;
    push_code      = cmd_r.code;
    end_done       = 1'b0;
    res            = '0;
    res.out_kind   = KIND_OP;
    res.out_symbol = top_code;

    case (state_r)
      S_IDLE: begin
        // close the previous word's final result, then fetch
        if (pend_valid_r && out_free) flush = 1'b1;
        if (q_valid && (!pend_valid_r || out_free)) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          phase_nxt = 1'b0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (err_r && cmd_r.op != OP_END) begin
          state_nxt = S_IDLE;
        end else begin
          case (cmd_r.op)
            OP_NUM: begin
              if (can_emit) begin
                emit           = 1'b1;
                res.out_kind   = KIND_NUM;
                res.out_symbol = '0;
                res.out_number = cmd_r.number;
                state_nxt      = S_IDLE;
              end
            end
            OP_PUSH: begin
              if (!full) begin
                push      = 1'b1;
                state_nxt = S_IDLE;
              end else if (can_emit) begin
                emit           = 1'b1;
                res.out_kind   = KIND_NONE;
                res.out_symbol = '0;
                res.status     = ST_OVERFLOW;
                err_nxt        = 1'b1;
                state_nxt      = S_IDLE;
              end
            end
            OP_OPER: begin
              if (!empty && !top_lp && top_prec >= cmd_r.prec) begin
                if (can_emit) begin
                  emit    = 1'b1;
                  cnt_nxt = cnt_m1;
                end
              end else if (!full) begin
                push      = 1'b1;
                state_nxt = S_IDLE;
              end else if (can_emit) begin
                emit           = 1'b1;
                res.out_kind   = KIND_NONE;
                res.out_symbol = '0;
                res.status     = ST_OVERFLOW;
                err_nxt        = 1'b1;
                state_nxt      = S_IDLE;
              end
            end
            OP_RPAREN: begin
              if (!phase_r) begin
                if (!empty && !top_lp) begin
                  if (can_emit) begin
                    emit    = 1'b1;
                    cnt_nxt = cnt_m1;
                  end
                end else if (empty) begin
                  if (can_emit) begin
                    emit           = 1'b1;
                    res.out_kind   = KIND_NONE;
                    res.out_symbol = '0;
                    res.status     = ST_PAREN;
                    err_nxt        = 1'b1;
                    state_nxt      = S_IDLE;
                  end
                end else begin
                  // drop the matching left paren
                  cnt_nxt   = cnt_m1;
                  phase_nxt = 1'b1;
                end
              end else if (!empty && top_fn) begin
                if (can_emit) begin
                  emit      = 1'b1;
                  cnt_nxt   = cnt_m1;
                  state_nxt = S_IDLE;
                end
              end else begin
                state_nxt = S_IDLE;
              end
            end
            OP_INVALID: begin
              if (can_emit) begin
                emit           = 1'b1;
                res.out_kind   = KIND_NONE;
                res.out_symbol = '0;
                res.status     = ST_INVALID;
                err_nxt        = 1'b1;
                state_nxt      = S_IDLE;
              end
            end
            OP_END: begin
              if (!err_r && !empty && !top_lp) begin
                if (can_emit) begin
                  emit    = 1'b1;
                  cnt_nxt = cnt_m1;
                end
              end else if (can_emit) begin
                emit           = 1'b1;
                end_done       = 1'b1;
                res.out_kind   = KIND_NONE;
                res.out_symbol = '0;
                res.status     = (!err_r && !empty) ? ST_PAREN : ST_OK;
                cnt_nxt        = '0;
                err_nxt        = 1'b0;
                state_nxt      = S_IDLE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (push) cnt_nxt = cnt_r + CNT_W'(1);

    // hold each result until the next one shows whether it was the last
    if (emit) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_nxt.last  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = res;
      pend_valid_nxt = 1'b1;
    end
    if (flush) begin
      out_nxt        = pend_r;
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= 1'b0;
      cnt_r        <= '0;
      err_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[cnt_r[IDX_W-1:0]] <= push_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.out_kind == KIND_NONE) |-> out_r.last)
    else $error("status result not marked last");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> (out_r.out_kind == KIND_NONE))
    else $error("error status on a token result");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_done |=> (cnt_r == '0 && !err_r))
    else $error("end word left stack or error state");

endmodule

/* hdl/infix_to_postfix_converter.sv */
// Top level of the infix-to-postfix converter: front end, command queue
// and stack back end. Depends on itp_pkg, itp_front and itp_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one classified infix token per word,
//   or an end mark (command set) that flushes the operator stack.
//   out_valid/out_ready/out_data carry postfix results; last marks the
//   final result caused by an input word. Words that only push cause none.
// Flow:
//   The front registers each word into a two-entry queue. The back fetches
//   a command in S_IDLE, then runs it in S_RUN one stack step at a time,
//   with one result per cycle while popping unless the output stalls. Each
//   result is held in a pending register until its last flag is known,
//   then moves to the output register.
// Reset clears the stack count, the error flag, the queue and all valids.
// When out_ready is low the output register holds; the back stalls on its
// next result and the queue fills, then in_ready drops.
module infix_to_postfix_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  itp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output itp_pkg::out_item_t out_data
);
  import itp_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  itp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  itp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* test/infix_to_postfix_converter_tb.sv */
// Self-checking bench for infix_to_postfix_converter: random-gap driver and sink
// around the block, with a shunting-yard predictor that queues the postfix words.
// Depends on itp_pkg and the converter RTL only.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam logic       CMD_TOKEN  = 1'b0;
  localparam logic       CMD_END    = 1'b1;
  localparam logic [2:0] TK_BAD     = 3'd4;

  localparam logic [3:0] SYM_ADD    = 4'd0;
  localparam logic [3:0] SYM_SUB    = 4'd1;
  localparam logic [3:0] SYM_MUL    = 4'd2;
  localparam logic [3:0] SYM_DIV    = 4'd3;
  localparam logic [3:0] SYM_MOD    = 4'd4;
  localparam logic [3:0] SYM_POW    = 4'd5;
  localparam logic [3:0] SYM_SEN    = 4'd6;
  localparam logic [3:0] SYM_COS    = 4'd7;
  localparam logic [3:0] SYM_TG     = 4'd8;
  localparam logic [3:0] SYM_LOG    = 4'd9;
  localparam logic [3:0] SYM_RAIZ   = 4'd10;
  localparam logic [3:0] SYM_ABS    = 4'd11;
  localparam logic [3:0] SYM_UNUSED = 4'd13;

  localparam int RANDOM_ITEMS   = 180;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  token_q[$];    // words waiting to be driven
  out_item_t postfix_q[$];  // postfix words still owed by the block

  // predictor state
  logic [3:0] op_stk[STACK_DEPTH];
  int         stk_depth = 0;
  bit         err_latched = 1'b0;

  int  in_wait = 0;
  int  out_wait = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  int  idle_cycles = 0;
  int  mismatch_cnt = 0;

  infix_to_postfix_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int rank_of(input logic [3:0] code);
    int r;
    case (code)
      SYM_ADD, SYM_SUB:                            r = 1;
      SYM_MUL, SYM_DIV, SYM_MOD:                   r = 2;
      SYM_POW, SYM_RAIZ:                           r = 3;
      SYM_SEN, SYM_COS, SYM_TG, SYM_LOG, SYM_ABS:  r = 4;
      default:                                     r = 0;
    endcase
    return r;
  endfunction

  function automatic bit is_unary_fn(input logic [3:0] code);
    return (code >= SYM_SEN) && (code <= SYM_ABS);
  endfunction

  task automatic emit(input logic [1:0] kind, input logic [3:0] sym,
                      input logic [31:0] num, input logic [1:0] st);
    out_item_t r;
    r.out_kind   = kind;
    r.out_symbol = sym;
    r.out_number = num;
    r.status     = st;
    r.last       = 1'b0;
    postfix_q.push_back(r);
  endtask

  task automatic pop_emit();
    stk_depth--;
    emit(KIND_OP, op_stk[stk_depth], '0, ST_OK);
  endtask

  task automatic raise(input logic [1:0] st);
    err_latched = 1'b1;
    emit(KIND_NONE, '0, '0, st);
  endtask

  task automatic push_code(input logic [3:0] code);
    if (stk_depth >= STACK_DEPTH) begin
      raise(ST_OVERFLOW);
    end else begin
      op_stk[stk_depth] = code;
      stk_depth++;
    end
  endtask

  task automatic convert_token(input in_item_t w);
    int         base;
    int         p;
    logic [1:0] st;
    out_item_t  tail;
    base = postfix_q.size();
    if (w.command == CMD_END) begin
      st = ST_OK;
      if (!err_latched) begin
        // flush stops at the first open paren
        while (stk_depth > 0 && st == ST_OK) begin
          stk_depth--;
          if (op_stk[stk_depth] == SYM_LPAREN) st = ST_PAREN;
          else emit(KIND_OP, op_stk[stk_depth], '0, ST_OK);
        end
      end
      emit(KIND_NONE, '0, '0, st);
      stk_depth   = 0;
      err_latched = 1'b0;
    end else if (!err_latched) begin
      case (w.token_kind)
        TK_NUM: emit(KIND_NUM, '0, w.number_bits, ST_OK);
        TK_OP: begin
          if (w.symbol_code > SYM_LAST_VALID) begin
            raise(ST_INVALID);
          end else if (is_unary_fn(w.symbol_code)) begin
            push_code(w.symbol_code);
          end else begin
            p = rank_of(w.symbol_code);
            while (stk_depth > 0 && op_stk[stk_depth-1] != SYM_LPAREN &&
                   rank_of(op_stk[stk_depth-1]) >= p)
              pop_emit();
            push_code(w.symbol_code);
          end
        end
        TK_LPAREN: push_code(SYM_LPAREN);
        TK_RPAREN: begin
          while (stk_depth > 0 && op_stk[stk_depth-1] != SYM_LPAREN) pop_emit();
          if (stk_depth == 0) begin
            raise(ST_PAREN);
          end else begin
            stk_depth--;
            if (stk_depth > 0 && is_unary_fn(op_stk[stk_depth-1])) pop_emit();
          end
        end
        default: raise(ST_INVALID);
      endcase
    end
    if (postfix_q.size() > base) begin
      tail = postfix_q.pop_back();
      tail.last = 1'b1;
      postfix_q.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(input logic cmd, input logic [2:0] kind,
                          input logic [3:0] sym, input logic [31:0] num);
    in_item_t w;
    w.command     = cmd;
    w.token_kind  = kind;
    w.symbol_code = sym;
    w.number_bits = num;
    token_q.push_back(w);
  endtask

  // fields the block ignores get random values
  task automatic add_num(input logic [31:0] v);
    add_item(CMD_TOKEN, TK_NUM, 4'($urandom_range(0, 15)), v);
  endtask

  task automatic add_op(input logic [3:0] code);
    add_item(CMD_TOKEN, TK_OP, code, $urandom);
  endtask

  task automatic add_lp();
    add_item(CMD_TOKEN, TK_LPAREN, 4'($urandom_range(0, 15)), $urandom);
  endtask

  task automatic add_rp();
    add_item(CMD_TOKEN, TK_RPAREN, 4'($urandom_range(0, 15)), $urandom);
  endtask

  task automatic add_end();
    add_item(CMD_END, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_expr(input int lvl);
    int pick;
    pick = (lvl >= 4) ? 0 : $urandom_range(0, 5);
    case (pick)
      0, 1: add_num(rand_num());
      2: begin
        add_op(4'($urandom_range(SYM_SEN, SYM_ABS)));
        if ($urandom_range(0, 2) != 0) begin
          add_lp();
          gen_expr(lvl + 1);
          add_rp();
        end else begin
          gen_expr(lvl + 1);
        end
      end
      3: begin
        add_lp();
        gen_expr(lvl + 1);
        add_rp();
      end
      default: begin
        gen_expr(lvl + 1);
        add_op(4'($urandom_range(SYM_ADD, SYM_POW)));
        gen_expr(lvl + 1);
      end
    endcase
  endtask

  // pile up nested parens and functions around the stack limit
  task automatic gen_deep();
    bit fn_only;
    fn_only = ($urandom_range(0, 2) == 0);
    repeat ($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2)) begin
      if (fn_only || $urandom_range(0, 2) == 0) add_op(4'($urandom_range(SYM_SEN, SYM_ABS)));
      else add_lp();
    end
    add_num(rand_num());
    if ($urandom_range(0, 1)) add_op(4'($urandom_range(SYM_ADD, SYM_POW)));
    if ($urandom_range(0, 1)) add_rp();
    add_end();
  endtask

  task automatic gen_broken();
    gen_expr(1);
    case ($urandom_range(0, 2))
      0: begin
        add_rp();
        add_num(rand_num());
      end
      1: begin
        add_lp();
        gen_expr(2);
      end
      default: add_op(4'($urandom_range(SYM_ADD, SYM_POW)));
    endcase
    add_end();
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6))
      add_item(logic'($urandom_range(0, 9) == 0), 3'($urandom_range(0, 7)),
               4'($urandom_range(0, 15)), $urandom);
    add_end();
  endtask

  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : feed
    bit hold;
    hold = in_valid && !in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else begin
      if (in_valid && in_ready) convert_token(in_data);
      if (!hold) begin
        if (in_wait > 0) begin
          in_wait  <= in_wait - 1;
          in_valid <= 1'b0;
        end else if (token_q.size() > 0) begin
          in_data  <= token_q.pop_front();
          in_valid <= 1'b1;
          in_wait  <= draw_wait(in_calm);
          if ($urandom_range(0, 19) == 0) in_calm <= !in_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : sink
    out_item_t want;
    int        w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = postfix_q.pop_front();
        check_field("out_kind",   32'(want.out_kind),   32'(out_data.out_kind));
        check_field("out_symbol", 32'(want.out_symbol), 32'(out_data.out_symbol));
        check_field("out_number", want.out_number,      out_data.out_number);
        check_field("status",     32'(want.status),     32'(out_data.status));
        check_field("last",       32'(want.last),       32'(out_data.last));
      end
      w = draw_wait(out_calm);
      if ($urandom_range(0, 19) == 0) out_calm <= !out_calm;
      out_wait  <= w;
      out_ready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait  <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int base;
    int k;

    // abs ( 0 + max * sen n ) - cos n
    add_op(SYM_ABS); add_lp(); add_num('0); add_op(SYM_ADD); add_num('1);
    add_op(SYM_MUL); add_op(SYM_SEN); add_num($urandom); add_rp();
    add_op(SYM_SUB); add_op(SYM_COS); add_num($urandom); add_end();
    // log ( n / n % n ^ raiz tg n, paren left open at the end
    add_op(SYM_LOG); add_lp(); add_num($urandom); add_op(SYM_DIV); add_num($urandom);
    add_op(SYM_MOD); add_num($urandom); add_op(SYM_POW); add_op(SYM_RAIZ);
    add_op(SYM_TG); add_num($urandom); add_end();
    // stray right paren pops the stack, then tokens are dropped until the end
    add_op(SYM_SUB); add_num($urandom); add_rp(); add_num($urandom); add_end();
    // bad token kind, then bad symbol code
    add_item(CMD_TOKEN, TK_BAD, SYM_ADD, $urandom); add_end();
    add_op(SYM_UNUSED); add_num($urandom); add_end();

    base = token_q.size();
    k = 0;
    while (token_q.size() < base + RANDOM_ITEMS) begin
      if (k % 9 == 4) begin
        gen_deep();
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    gen_broken();
          2:       gen_noise();
          default: begin
            gen_expr(0);
            add_end();
          end
        endcase
      end
      k++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (token_q.size() > 0 || in_valid) @(posedge clk);
    while (postfix_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && postfix_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hdl/itp_pkg.sv
hdl/itp_front.sv
hdl/itp_back.sv
hdl/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
